// File: hw/rtl/mcmq_pkg.sv
// Package for the multi-channel message queue: sizes, codes and the
// command record passed from front to back. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcmq_pkg;
  localparam int CHANNELS = 8;
  localparam int MESSAGES_PER_CHANNEL = 16;
  localparam int MAX_MESSAGE_BYTES = 32;
  localparam int CH_W = $clog2(CHANNELS);
  localparam int SLOT_W = $clog2(MESSAGES_PER_CHANNEL);
  localparam int BYTE_W = $clog2(MAX_MESSAGE_BYTES);
  localparam int LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CNT_W = $clog2(MESSAGES_PER_CHANNEL + 1);

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_RECV = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_NOFREE = 3'd4;

  // one command handed from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] channel;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    logic [5:0] max_bytes;
  } cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/multi_channel_message_queue.sv
// Top level of the multi-channel message queue: front queue and back engine.
// Depends on mcmq_pkg, mcmq_front, mcmq_back.
//
// channel  dir  tdata (low bit up)                              tuser  tlast
// s_axis   in   operation, channel, data_byte, has_byte, max_bytes  -    last
// m_axis   out  status, channel_id, byte_count, data_byte_out      -    last_out
//
// An input transfer is registered in the front queue before it reaches the back
// engine; each result is held in the output register until it is taken.
// Create, send byte and close are handled in the command state. A receive passes
// through the command state, then a payload read state and a transfer state per
// byte; a zero-byte delivery gives its single result from the read state.
// Reset is synchronous; no clearing pass, message memories need none.
// Either side may stall; a two-entry queue decouples input from the engine.
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_message_queue import mcmq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // operation, channel, data_byte, has_byte, max_bytes
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // status, channel_id, byte_count, data_byte_out
  output logic             m_axis_tlast
);
  cmd_t in_cmd, cmd;
  logic cmd_valid, cmd_ready;
  logic [2:0] st, id;
  logic [5:0] cnt;
  logic [7:0] byt;

  assign in_cmd.op = s_axis_tdata[1:0];
  assign in_cmd.channel = s_axis_tdata[5:2];
  assign in_cmd.data_byte = s_axis_tdata[13:6];
  assign in_cmd.has_byte = s_axis_tdata[14];
  assign in_cmd.max_bytes = s_axis_tdata[20:15];
  assign in_cmd.last = s_axis_tlast;

  mcmq_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
    .cmd_valid, .cmd_ready, .cmd
  );

  mcmq_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(st), .out_channel_id(id), .out_byte_count(cnt),
    .out_data_byte(byt), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, byt, cnt, id, st};

  logic unused_in;
  assign unused_in = ^s_axis_tdata[23:21];

  // a result with a byte count never exceeds the limit
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[11:6] <= 6'(MAX_MESSAGE_BYTES))
    else $error("byte count above limit");
  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // create reports a channel id only with ok status
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5:3] != 3'd0 |-> m_axis_tdata[2:0] == ST_OK)
    else $error("channel id with error status");
endmodule
`default_nettype wire

// File: hw/rtl/mcmq_front.sv
// Front: a two-entry command queue that registers the input.
// Depends on mcmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcmq_front import mcmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready,
  output cmd_t      cmd
);
  cmd_t q [2];
  logic [1:0] fill;
  logic push, pop;

  assign in_ready = (fill != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = cmd_valid && cmd_ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd = q[0];

  // queue storage, head at entry 0
  always_ff @(posedge clk) begin
    if (pop) begin
      q[0] <= (push && fill == 2'd1) ? in_cmd : q[1];
    end else if (push) begin
      if (fill == 2'd0) q[0] <= in_cmd;
      else q[1] <= in_cmd;
    end
  end

  // fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/mcmq_back.sv
// Back: channel state, message memories and result sequencer.
// Depends on mcmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcmq_back import mcmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [2:0] out_status,
  output logic [2:0] out_channel_id,
  output logic [5:0] out_byte_count,
  output logic [7:0] out_data_byte,
  output logic      out_last
);
  localparam logic [1:0] S_CMD = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  localparam int MSG_A = CH_W + SLOT_W;
  localparam int PAY_A = MSG_A + BYTE_W;

  logic [1:0] state;
  logic [CHANNELS-1:0] channel_open;
  logic [SLOT_W-1:0] write_slot [CHANNELS];
  logic [SLOT_W-1:0] read_slot [CHANNELS];
  logic [CNT_W-1:0] message_count [CHANNELS];
  logic [LEN_W-1:0] message_length [CHANNELS*MESSAGES_PER_CHANNEL];
  logic [7:0] payload_store [CHANNELS*MESSAGES_PER_CHANNEL*MAX_MESSAGE_BYTES];

  logic send_active;
  logic [LEN_W-1:0] send_byte_index;
  logic [2:0] send_status;
  logic [CH_W-1:0] send_channel;

  // receive sequencer
  logic [PAY_A-1:0] rd_base;
  logic [LEN_W-1:0] rd_idx, rd_n;
  logic [LEN_W-1:0] rd_len;
  logic [LEN_W-1:0] rd_max;
  logic [7:0] rd_byte;

  // output register
  logic ov;
  logic [2:0] o_st, o_id;
  logic [5:0] o_cnt;
  logic [7:0] o_byte;
  logic o_last;
  logic o_free;

  assign out_valid = ov;
  assign out_status = o_st;
  assign out_channel_id = o_id;
  assign out_byte_count = o_cnt;
  assign out_data_byte = o_byte;
  assign out_last = o_last;
  assign o_free = !ov || out_ready;
  assign cmd_ready = (state == S_CMD) && o_free;

  // command decode
  logic take;
  logic [CH_W-1:0] ch;
  logic ch_ok;
  logic first;
  logic [2:0] st_now;
  logic [CH_W-1:0] s_ch;
  logic [CH_W-1:0] free_ch;
  logic any_free;
  logic [5:0] maxb;

  assign take = cmd_valid && cmd_ready;
  assign ch = cmd.channel[CH_W-1:0];
  assign ch_ok = ({28'd0, cmd.channel} < CHANNELS) && channel_open[ch];
  assign first = !send_active;
  assign s_ch = first ? ch : send_channel;
  assign maxb = (cmd.max_bytes > 6'(MAX_MESSAGE_BYTES)) ? 6'(MAX_MESSAGE_BYTES)
                                                        : cmd.max_bytes;

  always_comb begin
    if (!first) st_now = send_status;
    else if (!ch_ok) st_now = ST_BAD;
    else if (message_count[ch] >= CNT_W'(MESSAGES_PER_CHANNEL)) st_now = ST_FULL;
    else st_now = ST_OK;
  end

  // lowest free channel, small priority search
  always_comb begin
    free_ch = '0;
    any_free = 1'b0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!channel_open[i]) begin
        free_ch = CH_W'(i);
        any_free = 1'b1;
      end
    end
  end

  logic wr_byte;
  assign wr_byte = take && cmd.op == OP_SEND && st_now == ST_OK && cmd.has_byte
                   && send_byte_index < LEN_W'(MAX_MESSAGE_BYTES);

  // payload and length memories
  always_ff @(posedge clk) begin
    if (wr_byte)
      payload_store[{s_ch, write_slot[s_ch], send_byte_index[BYTE_W-1:0]}] <= cmd.data_byte;
    if (take && cmd.op == OP_SEND && cmd.last && st_now == ST_OK)
      message_length[{s_ch, write_slot[s_ch]}] <=
        send_byte_index + LEN_W'(wr_byte);
    rd_byte <= payload_store[rd_base + PAY_A'(rd_idx[BYTE_W-1:0])];
    if (take) rd_len <= message_length[{ch, read_slot[ch]}];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CMD;
      channel_open <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        write_slot[i] <= '0;
        read_slot[i] <= '0;
        message_count[i] <= '0;
      end
      send_active <= 1'b0;
      send_byte_index <= '0;
      send_status <= ST_OK;
      send_channel <= '0;
      ov <= 1'b0;
      rd_idx <= '0;
      rd_n <= '0;
    end else begin
      if (ov && out_ready) ov <= 1'b0;
      unique case (state)
        S_CMD: begin
          if (take) begin
            o_st <= ST_OK; o_id <= '0; o_cnt <= '0; o_byte <= '0; o_last <= 1'b1;
            if (cmd.op != OP_SEND) begin
              send_active <= 1'b0;
              send_byte_index <= '0;
            end
            unique case (cmd.op)
              OP_CREATE: begin
                ov <= 1'b1;
                if (any_free) begin
                  channel_open[free_ch] <= 1'b1;
                  o_id <= 3'(free_ch);
                end else o_st <= ST_NOFREE;
              end
              OP_SEND: begin
                if (first) begin
                  send_channel <= ch;
                  send_status <= st_now;
                end
                if (cmd.last) begin
                  ov <= 1'b1;
                  o_st <= st_now;
                  send_active <= 1'b0;
                  send_byte_index <= '0;
                  if (st_now == ST_OK) begin
                    write_slot[s_ch] <= write_slot[s_ch] + 1'b1;
                    message_count[s_ch] <= message_count[s_ch] + 1'b1;
                  end
                end else begin
                  send_active <= 1'b1;
                  send_byte_index <= send_byte_index + LEN_W'(wr_byte);
                end
              end
              OP_RECV: begin
                if (!ch_ok) begin
                  ov <= 1'b1; o_st <= ST_BAD;
                end else if (message_count[ch] == '0) begin
                  ov <= 1'b1; o_st <= ST_EMPTY;
                end else begin
                  read_slot[ch] <= read_slot[ch] + 1'b1;
                  message_count[ch] <= message_count[ch] - 1'b1;
                  rd_base <= {ch, read_slot[ch], BYTE_W'(0)};
                  rd_max <= LEN_W'(maxb);
                  rd_idx <= '0;
                  state <= S_READ;
                end
              end
              default: begin
                ov <= 1'b1;
                if ({28'd0, cmd.channel} >= CHANNELS) o_st <= ST_BAD;
                else begin
                  channel_open[ch] <= 1'b0;
                  write_slot[ch] <= '0;
                  read_slot[ch] <= '0;
                  message_count[ch] <= '0;
                end
              end
            endcase
          end
        end
        S_READ: begin
          // length known; fix count, first byte address presented
          rd_n <= (rd_len < rd_max) ? rd_len : rd_max;
          if (rd_len == '0 || rd_max == '0) begin
            if (o_free) begin
              ov <= 1'b1; o_st <= ST_OK; o_cnt <= '0; o_byte <= '0; o_last <= 1'b1;
              state <= S_CMD;
            end
          end else state <= S_HOLD;
        end
        default: begin
          // one byte a step; the read address advances after each transfer
          if (o_free) begin
            ov <= 1'b1;
            o_st <= ST_OK; o_id <= '0;
            o_cnt <= 6'(rd_n);
            o_byte <= rd_byte;
            o_last <= (rd_idx + 1'b1 == rd_n);
            if (rd_idx + 1'b1 == rd_n) state <= S_CMD;
            else begin
              rd_idx <= rd_idx + 1'b1;
              state <= S_READ;
            end
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for multi_channel_message_queue: stream stimulus,
// an in-bench channel/message predictor and an in-order result scoreboard.
// Depends on mcmq_pkg and the multi_channel_message_queue RTL.
`timescale 1ns / 1ps
module tb;
  import mcmq_pkg::*;

  // one input transfer
  typedef struct {
    logic [1:0] op;
    logic [3:0] ch;
    logic [7:0] data;
    logic       has;
    logic       lst;
    logic [5:0] maxb;
  } msg_cmd_t;

  // one output transfer
  typedef struct {
    logic [2:0] status;
    logic [2:0] chan_id;
    logic [5:0] count;
    logic [7:0] data;
    logic       lst;
  } msg_rsp_t;

  // directed row: command plus optional hand-typed expectation
  typedef struct {
    msg_cmd_t   cmd;
    bit         typed;
    logic [2:0] status;
    logic [2:0] chan_id;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  multi_channel_message_queue dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // predictor state
  bit         chan_open [CHANNELS];
  logic [3:0] wr_slot [CHANNELS];
  logic [3:0] rd_slot [CHANNELS];
  int         msg_count [CHANNELS];
  int         msg_len [CHANNELS * MESSAGES_PER_CHANNEL];
  logic [7:0] payload [CHANNELS * MESSAGES_PER_CHANNEL * MAX_MESSAGE_BYTES];
  bit         run_open;
  int         run_index;
  logic [2:0] run_status;
  int         run_chan;

  msg_rsp_t expected_q[$];
  int       errors;
  int       idle_pct_in;
  int       idle_pct_out;
  int       hold_cycles;
  bit       done;
  longint   cycle;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle);
    errors++;
  endtask

  function automatic msg_rsp_t mk_rsp(logic [2:0] st, logic [2:0] id, logic [5:0] n,
                                      logic [7:0] d, logic l);
    msg_rsp_t r;
    r.status = st; r.chan_id = id; r.count = n; r.data = d; r.lst = l;
    return r;
  endfunction

  // advance the predictor by one command and queue the results it causes
  task automatic predict_queue(input msg_cmd_t c);
    int ch;
    int slot;
    int n;
    int base;
    bit found;
    ch = c.ch;
    if (c.op != OP_SEND) begin
      run_open = 0;
      run_index = 0;
    end
    case (c.op)
      OP_CREATE: begin
        found = 0;
        for (int i = 0; i < CHANNELS; i++)
          if (!found && !chan_open[i]) begin
            chan_open[i] = 1;
            found = 1;
            expected_q.push_back(mk_rsp(ST_OK, i[2:0], 0, 0, 1));
          end
        if (!found) expected_q.push_back(mk_rsp(ST_NOFREE, 0, 0, 0, 1));
      end
      OP_SEND: begin
        if (!run_open) begin
          run_open = 1;
          run_index = 0;
          run_chan = ch;
          if (ch >= CHANNELS || !chan_open[ch]) run_status = ST_BAD;
          else if (msg_count[ch] >= MESSAGES_PER_CHANNEL) run_status = ST_FULL;
          else run_status = ST_OK;
        end
        if (run_status == ST_OK && c.has && run_index < MAX_MESSAGE_BYTES) begin
          payload[(run_chan * MESSAGES_PER_CHANNEL + wr_slot[run_chan]) *
                  MAX_MESSAGE_BYTES + run_index] = c.data;
          run_index++;
        end
        if (c.lst) begin
          if (run_status == ST_OK) begin
            msg_len[run_chan * MESSAGES_PER_CHANNEL + wr_slot[run_chan]] = run_index;
            wr_slot[run_chan] = 4'(wr_slot[run_chan] + 1);
            msg_count[run_chan]++;
          end
          expected_q.push_back(mk_rsp(run_status, 0, 0, 0, 1));
          run_open = 0;
          run_index = 0;
        end
      end
      OP_RECV: begin
        if (ch >= CHANNELS || !chan_open[ch])
          expected_q.push_back(mk_rsp(ST_BAD, 0, 0, 0, 1));
        else if (msg_count[ch] == 0)
          expected_q.push_back(mk_rsp(ST_EMPTY, 0, 0, 0, 1));
        else begin
          slot = rd_slot[ch];
          n = (c.maxb > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : c.maxb;
          if (msg_len[ch * MESSAGES_PER_CHANNEL + slot] < n)
            n = msg_len[ch * MESSAGES_PER_CHANNEL + slot];
          rd_slot[ch] = 4'(rd_slot[ch] + 1);
          msg_count[ch]--;
          base = (ch * MESSAGES_PER_CHANNEL + slot) * MAX_MESSAGE_BYTES;
          if (n == 0) expected_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1));
          for (int i = 0; i < n; i++)
            expected_q.push_back(mk_rsp(ST_OK, 0, n[5:0], payload[base + i], i + 1 == n));
        end
      end
      default: begin
        if (ch >= CHANNELS) expected_q.push_back(mk_rsp(ST_BAD, 0, 0, 0, 1));
        else begin
          chan_open[ch] = 0;
          wr_slot[ch] = 0;
          rd_slot[ch] = 0;
          msg_count[ch] = 0;
          expected_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1));
        end
      end
    endcase
  endtask

  // offer one command with random sender gaps, return after its transfer
  task automatic send_cmd(input msg_cmd_t c);
    while ($urandom_range(99) < idle_pct_in) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {3'b0, c.maxb, c.has, c.data, c.ch, c.op};
    s_axis_tlast <= c.lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_queue(c);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic msg_cmd_t mk_cmd(logic [1:0] op, logic [3:0] ch, logic [7:0] d,
                                      logic h, logic l, logic [5:0] m);
    msg_cmd_t c;
    c.op = op; c.ch = ch; c.data = d; c.has = h; c.lst = l; c.maxb = m;
    return c;
  endfunction

  function automatic row_t mk_row(msg_cmd_t c, bit t, logic [2:0] st, logic [2:0] id);
    row_t r;
    r.cmd = c; r.typed = t; r.status = st; r.chan_id = id;
    return r;
  endfunction

  // receiver: random stalls, long hold-off on request, compare against queue
  initial begin
    msg_rsp_t got;
    msg_rsp_t want;
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.chan_id = m_axis_tdata[5:3];
        got.count = m_axis_tdata[11:6];
        got.data = m_axis_tdata[19:12];
        got.lst = m_axis_tlast;
        if (expected_q.size() == 0) begin
          $display("unexpected result transfer at cycle %0d", cycle);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.chan_id !== want.chan_id) report_mismatch("channel_id", got.chan_id, want.chan_id);
          if (got.count !== want.count) report_mismatch("byte_count", got.count, want.count);
          if (got.data !== want.data) report_mismatch("data_byte_out", got.data, want.data);
          if (got.lst !== want.lst) report_mismatch("last_out", got.lst, want.lst);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 0;
      end else
        m_axis_tready <= ($urandom_range(99) >= idle_pct_out);
    end
  end

  // cycle counter and timeout
  initial begin
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle > 400000) begin
        $display("multi_channel_message_queue test failed");
        $finish;
      end
    end
  end

  // a well-formed send run of n payload bytes, random extra noise on channel
  task automatic send_message(input int ch, input int n);
    if (n == 0) send_cmd(mk_cmd(OP_SEND, ch[3:0], 8'($urandom), 0, 1, 6'($urandom)));
    for (int i = 0; i < n; i++)
      send_cmd(mk_cmd(OP_SEND, (i == 0) ? ch[3:0] : 4'($urandom), 8'($urandom),
                      1, i == n - 1, 6'($urandom)));
  endtask

  task automatic random_item();
    int pick;
    int ch;
    pick = $urandom_range(99);
    ch = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(CHANNELS - 1);
    if (pick < 45) send_message(ch, ($urandom_range(9) == 0) ? $urandom_range(40)
                                                               : $urandom_range(6));
    else if (pick < 75) send_cmd(mk_cmd(OP_RECV, ch[3:0], 8'($urandom), 1'($urandom),
                                        1'($urandom),
                                        6'(($urandom_range(4) == 0) ? $urandom_range(63)
                                                                    : $urandom_range(8))));
    else if (pick < 85) send_cmd(mk_cmd(OP_CREATE, 4'($urandom), 8'($urandom), 1'($urandom),
                                        1'($urandom), 6'($urandom)));
    else if (pick < 90) send_cmd(mk_cmd(OP_CLOSE, ch[3:0], 8'($urandom), 1'($urandom),
                                        1'($urandom), 6'($urandom)));
    else send_cmd(mk_cmd(OP_SEND, ch[3:0], 8'($urandom), 1'($urandom), 1'($urandom),
                         6'($urandom)));
  endtask

  task automatic drain();
    go_idle();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  row_t rows[$];

  // main stimulus
  initial begin
    msg_rsp_t want;
    int phase_items;
    errors = 0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    hold_cycles = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_open[i] = 0; wr_slot[i] = 0; rd_slot[i] = 0; msg_count[i] = 0;
    end
    run_open = 0; run_index = 0; run_status = 0; run_chan = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table
    rows.push_back(mk_row(mk_cmd(OP_RECV, 0, 0, 0, 0, 32), 1, ST_BAD, 0));
    rows.push_back(mk_row(mk_cmd(OP_CREATE, 15, 255, 1, 1, 63), 1, ST_OK, 0));
    rows.push_back(mk_row(mk_cmd(OP_RECV, 0, 0, 0, 0, 32), 1, ST_EMPTY, 0));
    rows.push_back(mk_row(mk_cmd(OP_SEND, 0, 8'hff, 1, 0, 0), 0, 0, 0));
    rows.push_back(mk_row(mk_cmd(OP_SEND, 7, 8'h00, 1, 0, 0), 0, 0, 0));
    rows.push_back(mk_row(mk_cmd(OP_SEND, 15, 8'ha5, 1, 1, 0), 1, ST_OK, 0));
    rows.push_back(mk_row(mk_cmd(OP_SEND, 0, 0, 0, 1, 0), 1, ST_OK, 0));
    rows.push_back(mk_row(mk_cmd(OP_RECV, 0, 0, 0, 0, 63), 0, 0, 0));
    rows.push_back(mk_row(mk_cmd(OP_RECV, 0, 0, 0, 0, 32), 1, ST_OK, 0));
    rows.push_back(mk_row(mk_cmd(OP_SEND, 15, 1, 1, 1, 0), 1, ST_BAD, 0));
    rows.push_back(mk_row(mk_cmd(OP_SEND, 3, 1, 1, 1, 0), 1, ST_BAD, 0));
    rows.push_back(mk_row(mk_cmd(OP_SEND, 0, 9, 1, 0, 0), 0, 0, 0));
    rows.push_back(mk_row(mk_cmd(OP_RECV, 0, 0, 0, 0, 0), 1, ST_EMPTY, 0));
    rows.push_back(mk_row(mk_cmd(OP_SEND, 0, 7, 1, 1, 0), 1, ST_OK, 0));
    rows.push_back(mk_row(mk_cmd(OP_RECV, 0, 0, 1, 1, 0), 1, ST_OK, 0));
    rows.push_back(mk_row(mk_cmd(OP_CLOSE, 15, 0, 0, 0, 0), 1, ST_BAD, 0));
    rows.push_back(mk_row(mk_cmd(OP_CLOSE, 5, 0, 0, 0, 0), 1, ST_OK, 0));
    rows.push_back(mk_row(mk_cmd(OP_CLOSE, 0, 0, 0, 0, 0), 1, ST_OK, 0));
    for (int r = 0; r < rows.size(); r++) begin
      if (rows[r].typed) begin
        want = mk_rsp(rows[r].status, rows[r].chan_id, 0, 0, 1);
        send_cmd(rows[r].cmd);
        if (expected_q.size() == 0 || expected_q[$].status !== want.status ||
            expected_q[$].chan_id !== want.chan_id) begin
          $display("directed row %0d disagrees with predictor", r);
          errors++;
        end
      end else
        send_cmd(rows[r].cmd);
    end
    // all channels open, then no free channel
    for (int i = 0; i <= CHANNELS; i++)
      send_cmd(mk_cmd(OP_CREATE, 0, 0, 0, 0, 0));
    // overlong message, then fill a channel to full
    send_message(1, 40);
    for (int i = 0; i < MESSAGES_PER_CHANNEL; i++) send_message(2, 1);
    send_message(2, 2);
    send_cmd(mk_cmd(OP_RECV, 1, 0, 0, 0, 40));
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int p = 0; p < 4; p++) begin
      idle_pct_in = (p == 1) ? 61 : (p == 3) ? 31 : 0;
      idle_pct_out = (p == 2) ? 61 : (p == 3) ? 31 : 0;
      if (p == 2) hold_cycles = 300;
      phase_items = 0;
      while (phase_items < 30) begin
        random_item();
        phase_items++;
      end
      if (p == 1) drain();
    end
    idle_pct_in = 0;
    idle_pct_out = 0;
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("multi_channel_message_queue test passed");
    else
      $display("multi_channel_message_queue test failed");
    $finish;
  end
endmodule
